@@ rtl/ptpd_pkg.sv @@
// Shared types and constants for the point transform with perspective divide.
`timescale 1ns / 1ps
package ptpd_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;
  localparam bit CMD_LOAD = 1'b0;
  localparam bit CMD_XFORM = 1'b1;

  typedef struct packed {
    logic                     command;
    logic [3:0]               coef_index;
    logic [WORD_BITS_DEF-1:0] coef_value;
    logic [WORD_BITS_DEF-1:0] in_x;
    logic [WORD_BITS_DEF-1:0] in_y;
    logic [WORD_BITS_DEF-1:0] in_z;
  } in_word_t;

  typedef struct packed {
    logic [WORD_BITS_DEF-1:0] out_x;
    logic [WORD_BITS_DEF-1:0] out_y;
    logic [WORD_BITS_DEF-1:0] out_z;
    logic                     was_divided;
    logic                     saturated;
  } out_word_t;
endpackage

@@ rtl/point_transform_perspective_divide.sv @@
// Top level of the point transform with perspective divide.
// Usage: send words on the input channel (in_valid/in_stall/in_data).
// A load word (command 0) writes one row-major coefficient into the
// matrix store and gives no result. A transform word (command 1) gives
// one result word on the output channel (out_valid/out_stall/out_data).
// Four lanes form x, y, z and w in parallel with multipliers, then a
// merging stage picks rounding or the divider path per w.
// Throughput: one word per cycle while the receiver does not stall, set by
// the fully pipelined lanes and divider.
// Reset clears the pipeline valid bits and loads the identity matrix.
// When the receiver stalls a waiting result, the whole pipeline holds; in_stall is high
// while a result waits and the pipeline cannot advance.
// Loads take effect for transform words accepted after them.
`timescale 1ns / 1ps
module point_transform_perspective_divide #(
  parameter int FRAC_BITS = ptpd_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ptpd_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ptpd_pkg::out_word_t out_data
);
  localparam int WORD_BITS = ptpd_pkg::WORD_BITS_DEF;
  localparam int ACC_BITS = 2 * WORD_BITS + 3;
  localparam int QB = WORD_BITS + 1;
  localparam int DEPTH = QB + 5;

  logic signed [WORD_BITS-1:0] coef [16];
  logic en;
  logic [DEPTH-1:0] vld;
  logic signed [WORD_BITS-1:0] px, py, pz;
  logic signed [ACC_BITS-1:0] acc [4];
  logic signed [ACC_BITS-1:0] a3 [3];
  logic signed [ACC_BITS-1:0] w3;
  logic div3;
  logic [WORD_BITS-1:0] quo [3];
  logic dsat [3];
  logic [WORD_BITS-1:0] rnd_q [3];
  logic rsat_q [3];
  logic div_d [QB+1];
  logic [WORD_BITS-1:0] res [3];
  logic anysat;

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        coef[i] <= (i % 5 == 0) ? WORD_BITS'(1) << FRAC_BITS : '0;
      end
    end else if (in_valid && en && in_data.command == ptpd_pkg::CMD_LOAD) begin
      coef[in_data.coef_index] <= in_data.coef_value[WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid && in_data.command == ptpd_pkg::CMD_XFORM};
    end
  end

  assign px = in_data.in_x[WORD_BITS-1:0];
  assign py = in_data.in_y[WORD_BITS-1:0];
  assign pz = in_data.in_z[WORD_BITS-1:0];

  for (genvar c = 0; c < 4; c++) begin : g_lane
    ptpd_lane #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane (
      .clk(clk), .en(en), .px(px), .py(py), .pz(pz),
      .mx(coef[c]), .my(coef[4+c]), .mz(coef[8+c]), .mt(coef[12+c]),
      .acc(acc[c])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) a3[c] <= acc[c];
      w3 <= acc[3];
      div3 <= acc[3] != (ACC_BITS'(1) << (2 * FRAC_BITS)) && acc[3] != '0;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_merge
    logic signed [ACC_BITS-1:0] rs;
    logic [ACC_BITS-1:0] an, ad;
    logic [WORD_BITS-1:0] rnd_d [QB+1];
    logic rsat_d [QB+1];
    assign an = a3[c][ACC_BITS-1] ? -a3[c] : a3[c];
    assign ad = w3[ACC_BITS-1] ? -w3 : w3;
    assign rs = (a3[c] + (ACC_BITS'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    ptpd_divider #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
      .clk(clk), .en(en), .neg_in(a3[c][ACC_BITS-1] ^ w3[ACC_BITS-1]),
      .num(an), .den(ad), .quo(quo[c]), .sat(dsat[c])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        if (rs > $signed(ACC_BITS'({1'b0, {(WORD_BITS-1){1'b1}}}))) begin
          rnd_d[0] <= {1'b0, {(WORD_BITS-1){1'b1}}};
          rsat_d[0] <= 1'b1;
        end else if (rs < -(ACC_BITS'(1) <<< (WORD_BITS - 1))) begin
          rnd_d[0] <= {1'b1, {(WORD_BITS-1){1'b0}}};
          rsat_d[0] <= 1'b1;
        end else begin
          rnd_d[0] <= rs[WORD_BITS-1:0];
          rsat_d[0] <= 1'b0;
        end
        for (int k = 1; k <= QB; k++) begin
          rnd_d[k] <= rnd_d[k-1];
          rsat_d[k] <= rsat_d[k-1];
        end
      end
    end
    assign rnd_q[c] = rnd_d[QB];
    assign rsat_q[c] = rsat_d[QB];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_d[0] <= div3;
      for (int k = 1; k <= QB; k++) div_d[k] <= div_d[k-1];
    end
  end

  always_comb begin
    anysat = 1'b0;
    for (int c = 0; c < 3; c++) begin
      // hold the rounding path as long as the divider
      res[c] = div_d[QB] ? quo[c] : rnd_q[c];
      anysat = anysat | (div_d[QB] ? dsat[c] : rsat_q[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.out_x <= res[0];
      out_data.out_y <= res[1];
      out_data.out_z <= res[2];
      out_data.was_divided <= div_d[QB];
      out_data.saturated <= anysat;
    end
  end
endmodule

@@ rtl/ptpd_lane.sv @@
// One lane: dot product of the point with one matrix column, in two stages.
`timescale 1ns / 1ps
module ptpd_lane #(
  parameter int WORD_BITS = ptpd_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = ptpd_pkg::FRAC_BITS_DEF,
  localparam int ACC_BITS = 2 * WORD_BITS + 3
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [WORD_BITS-1:0] px,
  input  logic signed [WORD_BITS-1:0] py,
  input  logic signed [WORD_BITS-1:0] pz,
  input  logic signed [WORD_BITS-1:0] mx,
  input  logic signed [WORD_BITS-1:0] my,
  input  logic signed [WORD_BITS-1:0] mz,
  input  logic signed [WORD_BITS-1:0] mt,
  output logic signed [ACC_BITS-1:0]  acc
);
  logic signed [2*WORD_BITS-1:0] prx, pry, prz;
  logic signed [ACC_BITS-1:0] tr;

  always_ff @(posedge clk) begin
    if (en) begin
      prx <= px * mx;
      pry <= py * my;
      prz <= pz * mz;
      tr  <= ACC_BITS'(mt) <<< FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc <= tr + ACC_BITS'(prx) + ACC_BITS'(pry) + ACC_BITS'(prz);
    end
  end
endmodule

@@ rtl/ptpd_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage, with saturation.
`timescale 1ns / 1ps
module ptpd_divider #(
  parameter int WORD_BITS = ptpd_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = ptpd_pkg::FRAC_BITS_DEF,
  localparam int ACC_BITS = 2 * WORD_BITS + 3,
  localparam int QB = WORD_BITS + 1
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic                        neg_in,
  input  logic [ACC_BITS-1:0]         num,
  input  logic [ACC_BITS-1:0]         den,
  output logic [WORD_BITS-1:0]        quo,
  output logic                        sat
);
  localparam int NB = ACC_BITS + FRAC_BITS;
  // Quotient bits above QB mean overflow; detect with a compare first.
  logic [NB-1:0]  n_s [QB+1];
  logic [NB-1:0]  r_s [QB+1];
  logic [ACC_BITS-1:0] d_s [QB+1];
  logic [QB-1:0]  q_s [QB+1];
  logic           ov_s [QB+1];
  logic           ng_s [QB+1];
  logic [WORD_BITS-1:0] qmag;
  logic [WORD_BITS:0] qx;

  always_ff @(posedge clk) begin
    if (en) begin
      n_s[0]  <= {num, {FRAC_BITS{1'b0}}};
      r_s[0]  <= NB'(({num, {FRAC_BITS{1'b0}}}) >> QB);
      d_s[0]  <= den;
      q_s[0]  <= '0;
      ov_s[0] <= (NB'({num, {FRAC_BITS{1'b0}}}) >> QB) >= NB'(den);
      ng_s[0] <= neg_in;
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [NB-1:0] rin;
    assign rin = {r_s[i][NB-2:0], n_s[i][QB-1-i]};
    always_ff @(posedge clk) begin
      if (en) begin
        n_s[i+1]  <= n_s[i];
        d_s[i+1]  <= d_s[i];
        ov_s[i+1] <= ov_s[i];
        ng_s[i+1] <= ng_s[i];
        if (rin >= NB'(d_s[i])) begin
          r_s[i+1] <= rin - NB'(d_s[i]);
          q_s[i+1] <= {q_s[i][QB-2:0], 1'b1};
        end else begin
          r_s[i+1] <= rin;
          q_s[i+1] <= {q_s[i][QB-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    qmag = q_s[QB][WORD_BITS-1:0];
    qx = {q_s[QB][QB-1], qmag};
    sat = 1'b0;
    if (ov_s[QB] || (ng_s[QB] ? (qx > (WORD_BITS+1)'(1) << (WORD_BITS-1))
                              : q_s[QB][QB-1] || qmag[WORD_BITS-1])) begin
      sat = 1'b1;
      quo = ng_s[QB] ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
    end else begin
      quo = ng_s[QB] ? (~qmag + 1'b1) : qmag;
    end
  end
endmodule

@@ tb/ptpd_checker.sv @@
// Checker for the point transform: predicts each result word and compares it with the block output.
`timescale 1ns / 1ps
module ptpd_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  ptpd_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  ptpd_pkg::out_word_t out_data,
  output int                  fail_count,
  output int                  pending
);
  logic signed [31:0] matrix [16];
  ptpd_pkg::out_word_t result_queue [$];

  function automatic logic [31:0] clamp_word(input logic signed [127:0] v, inout logic sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic ptpd_pkg::out_word_t transform_point(input ptpd_pkg::in_word_t w_in);
    logic signed [127:0] acc [4];
    logic signed [127:0] pt [3];
    logic signed [127:0] r, num, den, q;
    logic divide, sat, ng;
    ptpd_pkg::out_word_t res;
    pt[0] = $signed(w_in.in_x);
    pt[1] = $signed(w_in.in_y);
    pt[2] = $signed(w_in.in_z);
    for (int c = 0; c < 4; c++) begin
      acc[c] = ($signed({{96{matrix[12 + c][31]}}, matrix[12 + c]}) <<< 16)
             + pt[0] * $signed({{96{matrix[c][31]}}, matrix[c]})
             + pt[1] * $signed({{96{matrix[4 + c][31]}}, matrix[4 + c]})
             + pt[2] * $signed({{96{matrix[8 + c][31]}}, matrix[8 + c]});
    end
    divide = (acc[3] != (128'sd1 <<< 32)) && (acc[3] != 0);
    sat = 1'b0;
    for (int c = 0; c < 3; c++) begin
      if (divide) begin
        ng = acc[c][127] != acc[3][127];
        num = (acc[c] < 0 ? -acc[c] : acc[c]) <<< 16;
        den = acc[3] < 0 ? -acc[3] : acc[3];
        q = $signed($unsigned(num) / $unsigned(den));
        r = ng ? -q : q;
      end else begin
        r = (acc[c] + 128'sd32768) >>> 16;
      end
      case (c)
        0: res.out_x = clamp_word(r, sat);
        1: res.out_y = clamp_word(r, sat);
        default: res.out_z = clamp_word(r, sat);
      endcase
    end
    res.was_divided = divide;
    res.saturated = sat;
    return res;
  endfunction

  assign pending = result_queue.size();

  always @(posedge clk) begin
    ptpd_pkg::out_word_t exp_word;
    if (rst) begin
      for (int i = 0; i < 16; i++) matrix[i] <= (i % 5 == 0) ? 32'sh10000 : 32'sd0;
      result_queue.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (in_data.command == ptpd_pkg::CMD_LOAD) begin
          matrix[in_data.coef_index] <= in_data.coef_value;
        end else begin
          result_queue.push_back(transform_point(in_data));
        end
      end
      if (out_valid && !out_stall) begin
        if (result_queue.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_word = result_queue.pop_front();
          if (exp_word !== out_data) begin
            $display({"%0t: mismatch, expected x %h y %h z %h div %b sat %b,",
                      " actual x %h y %h z %h div %b sat %b"},
                     $time, exp_word.out_x, exp_word.out_y, exp_word.out_z,
                     exp_word.was_divided, exp_word.saturated, out_data.out_x,
                     out_data.out_y, out_data.out_z, out_data.was_divided,
                     out_data.saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ tb/tb_point_transform_perspective_divide.sv @@
// Testbench top: drives load and transform words with random gaps and stalls, gives the verdict.
`timescale 1ns / 1ps
module tb_point_transform_perspective_divide;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  ptpd_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ptpd_pkg::out_word_t out_data;
  int fail_count;
  int pending;

  point_transform_perspective_divide DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  ptpd_checker checker_inst (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  always #1 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h00010000;
      3: return 32'hffff0000;
      4: return 32'h0;
      5: return $urandom_range(0, 32'h7ffff) - 32'h40000;
      default: return $urandom;
    endcase
  endfunction

  function automatic ptpd_pkg::in_word_t rand_word();
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(ptpd_pkg::in_word_t)-1:0];
  endfunction

  task automatic send_word(input ptpd_pkg::in_word_t w);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_load(input logic [3:0] idx, input logic [31:0] val);
    ptpd_pkg::in_word_t w;
    w = rand_word();
    w.command = ptpd_pkg::CMD_LOAD;
    w.coef_index = idx;
    w.coef_value = val;
    send_word(w);
  endtask

  task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    ptpd_pkg::in_word_t w;
    w = rand_word();
    w.command = ptpd_pkg::CMD_XFORM;
    w.in_x = x;
    w.in_y = y;
    w.in_z = z;
    send_word(w);
  endtask

  initial begin
    int g;
    @(posedge clk);
    forever begin
      g = $urandom_range(0, 3) == 0 ? gap_len() : 0;
      if (g != 0) begin
        out_stall <= 1'b1;
        repeat (g) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  initial begin
    int wait_cycles;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_point(32'h7fffffff, 32'h80000000, 32'h0);
    send_point(32'h00018000, 32'hffff8000, 32'h00000001);
    send_point(32'h80000000, 32'h7fffffff, 32'hffffffff);
    send_load(4'd15, 32'h00020000);
    send_point(32'h00030000, 32'hfffd0000, 32'h00050000);
    send_load(4'd15, 32'h0);
    send_point(32'h00030000, 32'h00040000, 32'h00070001);
    send_load(4'd3, 32'h00010000);
    send_point(32'h00000000, 32'h0, 32'h0);
    send_point(32'hffff0000, 32'h0, 32'h0);
    send_point(32'h00000001, 32'h0, 32'h0);
    send_load(4'd0, 32'h7fffffff);
    send_load(4'd5, 32'h80000000);
    send_point(32'h7fffffff, 32'h7fffffff, 32'h00010000);
    send_load(4'd3, 32'hfffffff0);
    send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    for (int i = 0; i < 950; i++) begin
      if ($urandom_range(0, 4) == 0) send_load(4'($urandom_range(0, 15)), rand_value());
      else send_point(rand_value(), rand_value(), rand_value());
    end
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("tb_point_transform_perspective_divide: PASS");
    else $display("tb_point_transform_perspective_divide: FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_point_transform_perspective_divide: FAIL");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/ptpd_pkg.sv
rtl/ptpd_lane.sv
rtl/ptpd_divider.sv
rtl/point_transform_perspective_divide.sv
tb/ptpd_checker.sv
tb/tb_point_transform_perspective_divide.sv
